// ----- design/mrrr_pkg.sv -----
// Package for the multi-reader record ring.
// Command codes, status codes, sequencer states and the header byte layout.
// No dependencies.
package mrrr_pkg;

    // Wide enough for any header walk sum (two 16-bit header fields plus offsets)
    localparam int WW = 20;

    typedef enum logic [2:0] {
        CMD_CLEAR      = 3'd0,
        CMD_ACQUIRE    = 3'd1,
        CMD_RELEASE    = 3'd2,
        CMD_APPEND     = 3'd3,
        CMD_APPEND_BYTE = 3'd4,
        CMD_READ       = 3'd5,
        CMD_READ_BYTE  = 3'd6
    } cmd_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_TOO_BIG = 2'd2;
    localparam logic [1:0] ST_REJECT  = 2'd3;

    localparam logic [3:0] RID_NONE = 4'd8;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SWEEP,
        S_EXEC,
        S_HRD,
        S_HWR,
        S_A_GOT0,
        S_A_PASS,
        S_A_WALK,
        S_A_ADD,
        S_A_SHORT,
        S_A_RD0,
        S_A_GOTZ,
        S_A_PLACE,
        S_A_PLACE2,
        S_A_UPD_RD,
        S_A_UPD_CMP,
        S_B_POS,
        S_B_GOT,
        S_RB_DATA,
        S_FIN
    } state_t;

    // byte k of a block header: length, then free bytes, both little-endian
    function automatic logic [7:0] hdr_byte(input logic [3:0] k, input logic [15:0] l,
                                            input logic [15:0] f);
        logic [7:0] b;
        case (k)
            4'd0:    b = l[7:0];
            4'd1:    b = l[15:8];
            4'd2:    b = f[7:0];
            4'd3:    b = f[15:8];
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

// ----- design/mrrr_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
// No dependencies.
module mrrr_ram #(
    parameter int DW    = 8,
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [DW-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [DW-1:0]                              rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- design/mrrr_ctrl.sv -----
// Command sequencer for the record ring: header walks, placement, reader updates.
// Depends on mrrr_pkg; drives the byte RAM and the reader position RAM.
module mrrr_ctrl #(
    parameter int BUF_BYTES = 4096,
    parameter int READERS   = 8,
    parameter int HDR_BYTES = 8
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          start,
    output logic                                          busy,
    input  mrrr_pkg::cmd_t                                command,
    input  logic [2:0]                                    reader,
    input  logic [12:0]                                   length,
    input  logic [7:0]                                    data_byte,
    output logic                                          done,
    output logic [1:0]                                    status,
    output logic [3:0]                                    reader_id,
    output logic [12:0]                                   record_length,
    output logic [7:0]                                    out_byte,
    output logic                                          last,
    output logic                                          mem_we,
    output logic [$clog2(BUF_BYTES)-1:0]                  mem_waddr,
    output logic [7:0]                                    mem_wdata,
    output logic [$clog2(BUF_BYTES)-1:0]                  mem_raddr,
    input  logic [7:0]                                    mem_rdata,
    output logic                                          pos_we,
    output logic [((READERS > 1) ? $clog2(READERS) : 1)-1:0] pos_waddr,
    output logic [$clog2(BUF_BYTES)-1:0]                  pos_wdata,
    output logic [((READERS > 1) ? $clog2(READERS) : 1)-1:0] pos_raddr,
    input  logic [$clog2(BUF_BYTES)-1:0]                  pos_rdata
);
    import mrrr_pkg::*;

    localparam int AW    = $clog2(BUF_BYTES);
    localparam int PW    = (READERS > 1) ? $clog2(READERS) : 1;
    localparam int CW    = $clog2(HDR_BYTES + 1);
    localparam int LIMIT = BUF_BYTES / HDR_BYTES + 2;
    localparam int GW    = $clog2(LIMIT + 2);
    localparam int NACQ  = (READERS < 8) ? READERS : 8;

    localparam logic [WW-1:0] BUFW  = WW'(BUF_BYTES);
    localparam logic [WW-1:0] HDRW  = WW'(HDR_BYTES);
    localparam logic [AW:0]   BUFA  = (AW + 1)'(BUF_BYTES);
    localparam logic [15:0]   EMPTY_FREE = 16'(BUF_BYTES - HDR_BYTES);
    localparam logic [CW-1:0] HLAST = CW'(HDR_BYTES - 1);
    localparam logic [CW-1:0] HRD_END = CW'(4);
    localparam logic [PW-1:0] PLAST = PW'(READERS - 1);

    state_t state_reg, state_next, ret_reg, ret_next;
    cmd_t   cmd_reg, cmd_next;
    logic [2:0]         rd_reg, rd_next;
    logic [12:0]        len_reg, len_next;
    logic [7:0]         dat_reg, dat_next;
    logic [AW-1:0]      wp_reg, wp_next;
    logic [READERS-1:0] busy_reg, busy_next;
    logic [READERS-1:0] pvalid_reg, pvalid_next;
    logic [AW:0]        acur_reg, acur_next;
    logic [12:0]        arem_reg, arem_next;
    logic [AW:0]        rcur_reg, rcur_next;
    logic [15:0]        rrem_reg, rrem_next;
    logic [AW:0]        hbase_reg, hbase_next;
    logic [CW-1:0]      hcnt_reg, hcnt_next;
    logic               hoob_reg, hoob_next;
    logic [15:0]        hlen_reg, hlen_next;
    logic [15:0]        hfree_reg, hfree_next;
    logic [15:0]        wlen_reg, wlen_next;
    logic [15:0]        wfree_reg, wfree_next;
    logic [AW-1:0]      hp_reg, hp_next;
    logic [AW-1:0]      lastp_reg, lastp_next;
    logic [15:0]        alen_reg, alen_next;
    logic [WW-1:0]      afree_reg, afree_next;
    logic [1:0]         pass_reg, pass_next;
    logic               all_reg, all_next;
    logic [AW-1:0]      rnxt_reg, rnxt_next;
    logic [PW-1:0]      idx_reg, idx_next;
    logic [AW-1:0]      bpos_reg, bpos_next;
    logic [GW-1:0]      guard_reg, guard_next;
    logic [AW:0]        sweep_reg, sweep_next;
    logic               done_reg, done_next;
    logic [1:0]         rstat_reg, rstat_next;
    logic [3:0]         rid_reg, rid_next;
    logic [12:0]        rlen_reg, rlen_next;
    logic [7:0]         rbyte_reg, rbyte_next;
    logic               rlast_reg, rlast_next;

    logic               accept;
    logic [WW-1:0]      need_w;
    logic               acq_found;
    logic [2:0]         acq_idx;
    logic [AW-1:0]      acur_c, rcur_c;
    logic               rd_ok;
    logic [PW-1:0]      ridx;
    logic [AW-1:0]      upd_p, bpos_in;
    logic               upd_move;
    logic [AW+1:0]      hb_addr;
    logic [WW-1:0]      walk_nxt, place_np, place_rem, place_t, got_nxt, step_nxt;
    logic [AW-1:0]      place_wp;
    logic [7:0]         hbyte;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    always_comb
    begin
        acq_found = 1'b0;
        acq_idx   = 3'd0;
        for (int i = 0; i < NACQ; i++)
        begin
            if (!acq_found && !busy_reg[i])
            begin
                acq_found = 1'b1;
                acq_idx   = 3'(i);
            end
        end
        need_w   = WW'(len_reg) + HDRW;
        acur_c   = (acur_reg >= BUFA) ? '0 : acur_reg[AW-1:0];
        rcur_c   = (rcur_reg >= BUFA) ? '0 : rcur_reg[AW-1:0];
        rd_ok    = (32'(rd_reg) < READERS);
        ridx     = PW'(rd_reg);
        upd_p    = pvalid_reg[idx_reg] ? pos_rdata : '0;
        bpos_in  = pvalid_reg[ridx] ? pos_rdata : '0;
        if (all_reg)
            upd_move = 1'b1;
        else if (rnxt_reg > lastp_reg)
            upd_move = (upd_p > lastp_reg) && (upd_p < rnxt_reg);
        else
            upd_move = (upd_p > lastp_reg) || (upd_p < rnxt_reg);
        hb_addr   = (AW + 2)'(hbase_reg) + (AW + 2)'(hcnt_reg);
        walk_nxt  = WW'(hp_reg) + WW'(alen_reg) + afree_reg + HDRW;
        place_np  = WW'(hp_reg) + HDRW + WW'(len_reg);
        place_wp  = (place_np >= BUFW) ? '0 : AW'(place_np);
        place_rem = afree_reg - need_w;
        place_t   = WW'(place_wp) + place_rem + HDRW;
        got_nxt   = WW'(bpos_reg) + HDRW + WW'(hlen_reg) + WW'(hfree_reg);
        step_nxt  = WW'(bpos_reg) + WW'(hfree_reg) + HDRW;
        hbyte     = hoob_reg ? 8'd0 : mem_rdata;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_SWEEP:
            begin
                if (sweep_reg == BUFA - 1'b1)
                    state_next = S_IDLE;
            end
            S_EXEC:
            begin
                state_next = S_FIN;
                case (cmd_reg)
                    CMD_CLEAR:
                    begin
                        state_next = S_HWR;
                        ret_next   = S_FIN;
                    end
                    CMD_APPEND:
                    begin
                        if (need_w <= BUFW - HDRW)
                        begin
                            state_next = S_HRD;
                            ret_next   = S_A_GOT0;
                        end
                    end
                    CMD_READ:
                    begin
                        if (rd_ok)
                            state_next = S_B_POS;
                    end
                    CMD_READ_BYTE:
                    begin
                        if (rrem_reg != 16'd0)
                            state_next = S_RB_DATA;
                    end
                    default: state_next = S_FIN;
                endcase
            end
            S_HRD:
            begin
                if (hcnt_reg == HRD_END)
                    state_next = ret_reg;
            end
            S_HWR:
            begin
                if (hcnt_reg == HLAST)
                    state_next = ret_reg;
            end
            S_A_GOT0: state_next = S_A_PASS;
            S_A_PASS:
            begin
                if (pass_reg == 2'd3)
                    state_next = S_FIN;
                else if (afree_reg >= need_w)
                    state_next = S_A_PLACE;
                else
                    state_next = S_A_WALK;
            end
            S_A_WALK:
            begin
                if (afree_reg >= need_w || walk_nxt >= BUFW)
                    state_next = S_A_SHORT;
                else
                begin
                    state_next = S_HRD;
                    ret_next   = S_A_ADD;
                end
            end
            S_A_ADD: state_next = S_A_WALK;
            S_A_SHORT:
            begin
                if (afree_reg < need_w)
                begin
                    state_next = S_HWR;
                    ret_next   = S_A_RD0;
                end
                else
                    state_next = S_A_PASS;
            end
            S_A_RD0:
            begin
                state_next = S_HRD;
                ret_next   = S_A_GOTZ;
            end
            S_A_GOTZ: state_next = S_A_PASS;
            S_A_PLACE:
            begin
                state_next = S_HWR;
                ret_next   = S_A_PLACE2;
            end
            S_A_PLACE2:
            begin
                state_next = S_HWR;
                ret_next   = S_A_UPD_RD;
            end
            S_A_UPD_RD: state_next = S_A_UPD_CMP;
            S_A_UPD_CMP:
            begin
                if (idx_reg == PLAST)
                    state_next = S_FIN;
                else
                    state_next = S_A_UPD_RD;
            end
            S_B_POS:
            begin
                if (bpos_in == wp_reg)
                    state_next = S_FIN;
                else
                begin
                    state_next = S_HRD;
                    ret_next   = S_B_GOT;
                end
            end
            S_B_GOT:
            begin
                if (hlen_reg != 16'd0 || bpos_reg == wp_reg || 32'(guard_reg) > LIMIT)
                    state_next = S_FIN;
                else
                begin
                    state_next = S_HRD;
                    ret_next   = S_B_GOT;
                end
            end
            S_RB_DATA: state_next = S_FIN;
            S_FIN:     state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // memory port drive
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = 8'd0;
        mem_raddr = '0;
        pos_we    = 1'b0;
        pos_waddr = '0;
        pos_wdata = '0;
        pos_raddr = '0;
        case (state_reg)
            S_SWEEP:
            begin
                mem_we    = 1'b1;
                mem_waddr = sweep_reg[AW-1:0];
                mem_wdata = (sweep_reg < (AW + 1)'(HDR_BYTES)) ?
                            hdr_byte(4'(sweep_reg), 16'd0, EMPTY_FREE) : 8'd0;
            end
            S_HWR:
            begin
                mem_we    = (hb_addr < (AW + 2)'(BUF_BYTES));
                mem_waddr = hb_addr[AW-1:0];
                mem_wdata = hdr_byte(4'(hcnt_reg), wlen_reg, wfree_reg);
            end
            S_HRD:
            begin
                mem_raddr = hb_addr[AW-1:0];
            end
            S_EXEC:
            begin
                case (cmd_reg)
                    CMD_ACQUIRE:
                    begin
                        pos_we    = acq_found;
                        pos_waddr = PW'(acq_idx);
                        pos_wdata = wp_reg;
                    end
                    CMD_APPEND_BYTE:
                    begin
                        mem_we    = (arem_reg != 13'd0);
                        mem_waddr = acur_c;
                        mem_wdata = dat_reg;
                    end
                    CMD_READ:      pos_raddr = ridx;
                    CMD_READ_BYTE: mem_raddr = rcur_c;
                    default:       mem_we = 1'b0;
                endcase
            end
            S_A_UPD_RD: pos_raddr = idx_reg;
            S_A_UPD_CMP:
            begin
                pos_we    = upd_move;
                pos_waddr = idx_reg;
                pos_wdata = rnxt_reg;
            end
            S_B_GOT:
            begin
                pos_we    = (hlen_reg != 16'd0);
                pos_waddr = ridx;
                pos_wdata = (got_nxt >= BUFW) ? '0 : AW'(got_nxt);
            end
            default: mem_we = 1'b0;
        endcase
    end

    // datapath
    always_comb
    begin
        cmd_next    = cmd_reg;
        rd_next     = rd_reg;
        len_next    = len_reg;
        dat_next    = dat_reg;
        wp_next     = wp_reg;
        busy_next   = busy_reg;
        pvalid_next = pvalid_reg;
        acur_next   = acur_reg;
        arem_next   = arem_reg;
        rcur_next   = rcur_reg;
        rrem_next   = rrem_reg;
        hbase_next  = hbase_reg;
        hcnt_next   = hcnt_reg;
        hoob_next   = hoob_reg;
        hlen_next   = hlen_reg;
        hfree_next  = hfree_reg;
        wlen_next   = wlen_reg;
        wfree_next  = wfree_reg;
        hp_next     = hp_reg;
        lastp_next  = lastp_reg;
        alen_next   = alen_reg;
        afree_next  = afree_reg;
        pass_next   = pass_reg;
        all_next    = all_reg;
        rnxt_next   = rnxt_reg;
        idx_next    = idx_reg;
        bpos_next   = bpos_reg;
        guard_next  = guard_reg;
        sweep_next  = sweep_reg;
        done_next   = 1'b0;
        rstat_next  = rstat_reg;
        rid_next    = rid_reg;
        rlen_next   = rlen_reg;
        rbyte_next  = rbyte_reg;
        rlast_next  = rlast_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = command;
                    rd_next    = reader;
                    len_next   = length;
                    dat_next   = data_byte;
                    rstat_next = ST_OK;
                    rid_next   = 4'd0;
                    rlen_next  = 13'd0;
                    rbyte_next = 8'd0;
                    rlast_next = 1'b0;
                end
            end
            S_SWEEP: sweep_next = sweep_reg + 1'b1;
            S_EXEC:
            begin
                case (cmd_reg)
                    CMD_CLEAR:
                    begin
                        busy_next   = '0;
                        pvalid_next = '0;
                        wp_next     = '0;
                        acur_next   = '0;
                        arem_next   = 13'd0;
                        rcur_next   = '0;
                        rrem_next   = 16'd0;
                        hbase_next  = '0;
                        wlen_next   = 16'd0;
                        wfree_next  = EMPTY_FREE;
                    end
                    CMD_ACQUIRE:
                    begin
                        if (acq_found)
                        begin
                            busy_next[PW'(acq_idx)]   = 1'b1;
                            pvalid_next[PW'(acq_idx)] = 1'b1;
                            rid_next = 4'(acq_idx);
                        end
                        else
                        begin
                            rstat_next = ST_EMPTY;
                            rid_next   = RID_NONE;
                        end
                    end
                    CMD_RELEASE:
                    begin
                        if (rd_ok)
                            busy_next[ridx] = 1'b0;
                    end
                    CMD_APPEND:
                    begin
                        if (need_w > BUFW - HDRW)
                            rstat_next = ST_REJECT;
                        else
                        begin
                            hbase_next = (AW + 1)'(wp_reg);
                            hp_next    = wp_reg;
                            lastp_next = wp_reg;
                            all_next   = 1'b0;
                        end
                    end
                    CMD_APPEND_BYTE:
                    begin
                        if (arem_reg == 13'd0)
                            rstat_next = ST_REJECT;
                        else
                        begin
                            acur_next = (AW + 1)'(acur_c) + 1'b1;
                            arem_next = arem_reg - 1'b1;
                        end
                    end
                    CMD_READ:
                    begin
                        rrem_next  = 16'd0;
                        rstat_next = ST_EMPTY;
                    end
                    CMD_READ_BYTE:
                    begin
                        if (rrem_reg == 16'd0)
                            rstat_next = ST_EMPTY;
                        else
                        begin
                            rcur_next  = (AW + 1)'(rcur_c) + 1'b1;
                            rrem_next  = rrem_reg - 1'b1;
                            rlast_next = (rrem_reg == 16'd1);
                        end
                    end
                    default: rstat_next = ST_OK;
                endcase
            end
            S_HRD:
            begin
                hoob_next = (hb_addr >= (AW + 2)'(BUF_BYTES));
                if (hcnt_reg == CW'(1))
                    hlen_next[7:0] = hbyte;
                if (hcnt_reg == CW'(2))
                    hlen_next[15:8] = hbyte;
                if (hcnt_reg == CW'(3))
                    hfree_next[7:0] = hbyte;
                if (hcnt_reg == HRD_END)
                begin
                    hfree_next[15:8] = hbyte;
                    hcnt_next = '0;
                end
                else
                    hcnt_next = hcnt_reg + 1'b1;
            end
            S_HWR:
            begin
                if (hcnt_reg == HLAST)
                    hcnt_next = '0;
                else
                    hcnt_next = hcnt_reg + 1'b1;
            end
            S_A_GOT0:
            begin
                alen_next  = hlen_reg;
                afree_next = WW'(hfree_reg);
                pass_next  = 2'd0;
            end
            S_A_PASS:
            begin
                if (pass_reg == 2'd3)
                    rstat_next = ST_REJECT;
            end
            S_A_WALK:
            begin
                if (afree_reg < need_w)
                begin
                    if (walk_nxt == WW'(lastp_reg))
                        all_next = 1'b1;
                    hbase_next = (AW + 1)'(walk_nxt);
                end
            end
            S_A_ADD: afree_next = afree_reg + WW'(hlen_reg) + WW'(hfree_reg) + HDRW;
            S_A_SHORT:
            begin
                pass_next  = pass_reg + 1'b1;
                hbase_next = (AW + 1)'(hp_reg);
                wlen_next  = alen_reg;
                wfree_next = afree_reg[15:0];
            end
            S_A_RD0: hbase_next = '0;
            S_A_GOTZ:
            begin
                hp_next    = '0;
                afree_next = WW'(hfree_reg) + WW'(hlen_reg);
                alen_next  = 16'd0;
            end
            S_A_PLACE:
            begin
                hbase_next = (AW + 1)'(hp_reg);
                wlen_next  = 16'(len_reg);
                wfree_next = 16'd0;
                acur_next  = (AW + 1)'(WW'(hp_reg) + HDRW);
                arem_next  = len_reg;
            end
            S_A_PLACE2:
            begin
                hbase_next = (AW + 1)'(place_np);
                wlen_next  = 16'd0;
                wfree_next = place_rem[15:0];
                wp_next    = place_wp;
                rnxt_next  = (place_t >= BUFW) ? '0 : AW'(place_t);
                idx_next   = '0;
            end
            S_A_UPD_CMP:
            begin
                if (upd_move)
                    pvalid_next[idx_reg] = 1'b1;
                idx_next = idx_reg + 1'b1;
            end
            S_B_POS:
            begin
                bpos_next  = bpos_in;
                hbase_next = (AW + 1)'(bpos_in);
                guard_next = '0;
            end
            S_B_GOT:
            begin
                if (hlen_reg != 16'd0)
                begin
                    pvalid_next[ridx] = 1'b1;
                    rlen_next = hlen_reg[12:0];
                    if (hlen_reg > 16'(len_reg))
                        rstat_next = ST_TOO_BIG;
                    else
                    begin
                        rstat_next = ST_OK;
                        rcur_next  = (AW + 1)'(WW'(bpos_reg) + HDRW);
                        rrem_next  = hlen_reg;
                    end
                end
                else if (!(bpos_reg == wp_reg || 32'(guard_reg) > LIMIT))
                begin
                    bpos_next  = (step_nxt >= BUFW) ? '0 : AW'(step_nxt);
                    hbase_next = (step_nxt >= BUFW) ? '0 : (AW + 1)'(step_nxt);
                    guard_next = guard_reg + 1'b1;
                end
            end
            S_RB_DATA: rbyte_next = mem_rdata;
            S_FIN:     done_next = 1'b1;
            default:   done_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_SWEEP;
            ret_reg    <= S_IDLE;
            wp_reg     <= '0;
            busy_reg   <= '0;
            pvalid_reg <= '0;
            acur_reg   <= '0;
            arem_reg   <= 13'd0;
            rcur_reg   <= '0;
            rrem_reg   <= 16'd0;
            hcnt_reg   <= '0;
            sweep_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            wp_reg     <= wp_next;
            busy_reg   <= busy_next;
            pvalid_reg <= pvalid_next;
            acur_reg   <= acur_next;
            arem_reg   <= arem_next;
            rcur_reg   <= rcur_next;
            rrem_reg   <= rrem_next;
            hcnt_reg   <= hcnt_next;
            sweep_reg  <= sweep_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        rd_reg    <= rd_next;
        len_reg   <= len_next;
        dat_reg   <= dat_next;
        hbase_reg <= hbase_next;
        hoob_reg  <= hoob_next;
        hlen_reg  <= hlen_next;
        hfree_reg <= hfree_next;
        wlen_reg  <= wlen_next;
        wfree_reg <= wfree_next;
        hp_reg    <= hp_next;
        lastp_reg <= lastp_next;
        alen_reg  <= alen_next;
        afree_reg <= afree_next;
        pass_reg  <= pass_next;
        all_reg   <= all_next;
        rnxt_reg  <= rnxt_next;
        idx_reg   <= idx_next;
        bpos_reg  <= bpos_next;
        guard_reg <= guard_next;
        rstat_reg <= rstat_next;
        rid_reg   <= rid_next;
        rlen_reg  <= rlen_next;
        rbyte_reg <= rbyte_next;
        rlast_reg <= rlast_next;
    end

    assign done          = done_reg;
    assign status        = rstat_reg;
    assign reader_id     = rid_reg;
    assign record_length = rlen_reg;
    assign out_byte      = rbyte_reg;
    assign last          = rlast_reg;

endmodule

// ----- design/multi_reader_record_ring.sv -----
// Top level of the multi-reader record ring.
// Depends on mrrr_pkg, mrrr_ram and mrrr_ctrl.
//
// One command per transfer: start is taken when busy is low, and the single result appears
// on the result ports for one cycle with done high; the receiver cannot stall it. After
// reset the block writes an empty-ring header and zeros to its byte memory, one byte a cycle,
// with busy high. Append begin reads the block headers from the write position, merging free
// space; when that is not enough it writes back the merged header and wraps to the start.
// It then writes the placed header and the one after it and updates the reader positions one
// by one; read begin reads the headers from the reader's position until it finds a record.
module multi_reader_record_ring #(
    parameter int BUF_BYTES = 4096,
    parameter int READERS   = 8,
    parameter int HDR_BYTES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  command,
    input  logic [2:0]  reader,
    input  logic [12:0] length,
    input  logic [7:0]  data_byte,
    output logic        done,
    output logic [1:0]  status,
    output logic [3:0]  reader_id,
    output logic [12:0] record_length,
    output logic [7:0]  out_byte,
    output logic        last
);
    import mrrr_pkg::*;

    localparam int AW = $clog2(BUF_BYTES);
    localparam int PW = (READERS > 1) ? $clog2(READERS) : 1;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata, mem_rdata;
    logic          pos_we;
    logic [PW-1:0] pos_waddr, pos_raddr;
    logic [AW-1:0] pos_wdata, pos_rdata;

    mrrr_ctrl #(
        .BUF_BYTES (BUF_BYTES),
        .READERS   (READERS),
        .HDR_BYTES (HDR_BYTES)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (cmd_t'(command)),
        .reader        (reader),
        .length        (length),
        .data_byte     (data_byte),
        .done          (done),
        .status        (status),
        .reader_id     (reader_id),
        .record_length (record_length),
        .out_byte      (out_byte),
        .last          (last),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata),
        .pos_we        (pos_we),
        .pos_waddr     (pos_waddr),
        .pos_wdata     (pos_wdata),
        .pos_raddr     (pos_raddr),
        .pos_rdata     (pos_rdata)
    );

    mrrr_ram #(
        .DW    (8),
        .DEPTH (BUF_BYTES)
    ) u_ring (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    mrrr_ram #(
        .DW    (AW),
        .DEPTH (READERS)
    ) u_pos (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

endmodule

// ----- verif/multi_reader_record_ring_tb.sv -----
// Self-checking testbench for multi_reader_record_ring: command transfers with random gaps,
// each result checked against a behavioural ring model kept in the testbench.
// Depends on mrrr_pkg and the multi_reader_record_ring RTL.
module multi_reader_record_ring_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mrrr_pkg::*;

    localparam int RING = 4096;
    localparam int NRD = 8;
    localparam int HDR = 8;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [2:0]  rd;
        logic [12:0] len;
        logic [7:0]  dat;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0]  st;
        logic [3:0]  rid;
        logic [12:0] rlen;
        logic [7:0]  ob;
        logic        lst;
    } answer_t;

    logic clk, rst_n, start, busy, done, last;
    logic [2:0] command, reader;
    logic [12:0] length, record_length;
    logic [7:0] data_byte, out_byte;
    logic [1:0] status;
    logic [3:0] reader_id;

    cmd_item_t pending_cmds[$];
    answer_t   expected_answers[$];
    int mismatches = 0;
    int cycles = 0;
    bit quiet_stretch = 0;

    // ring model state
    logic [7:0] mem [RING];
    int unsigned wp, busy_mask, rpos[NRD], a_cur, a_rem, r_cur, r_rem;

    multi_reader_record_ring uut (.*);

    always begin
        clk = 1'b0; #5;
        clk = 1'b1; #5;
    end

    function automatic int unsigned mrd(int unsigned a);
        return a < RING ? mem[a] : 0;
    endfunction

    function automatic void mwr(int unsigned a, int unsigned v);
        if (a < RING) mem[a] = v[7:0];
    endfunction

    function automatic int unsigned blk_len(int unsigned p);
        return mrd(p) | (mrd(p + 1) << 8);
    endfunction

    function automatic int unsigned blk_free(int unsigned p);
        return mrd(p + 2) | (mrd(p + 3) << 8);
    endfunction

    function automatic void put_header(int unsigned p, int unsigned l, int unsigned f);
        for (int unsigned i = 0; i < HDR; i++)
            mwr(p + i, i == 0 ? l : i == 1 ? l >> 8 : i == 2 ? f : i == 3 ? f >> 8 : 0);
    endfunction

    function automatic void ring_clear();
        busy_mask = 0;
        foreach (rpos[i]) rpos[i] = 0;
        wp = 0;
        put_header(0, 0, RING - HDR);
        a_cur = 0; a_rem = 0; r_cur = 0; r_rem = 0;
    endfunction

    function automatic logic [1:0] place_record(int unsigned len);
        int unsigned need, lastp, hp, hl, hf, np, nx, p;
        bit all, placed;
        need = len + HDR;
        lastp = wp; hp = wp; all = 0; placed = 0;
        if (need > RING - HDR) return ST_REJECT;
        hl = blk_len(hp);
        hf = blk_free(hp);
        for (int pass = 0; pass < 3 && !placed; pass++) begin
            if (hf >= need) begin
                placed = 1;
                break;
            end
            while (hf < need) begin
                nx = hp + hl + hf + HDR;
                if (nx == lastp) all = 1;
                if (nx >= RING) break;
                hf += blk_len(nx) + blk_free(nx) + HDR;
            end
            if (hf < need) begin
                put_header(hp, hl, hf);
                hp = 0;
                hl = blk_len(0);
                hf = blk_free(0) + hl;
                hl = 0;
            end
        end
        if (!placed) return ST_REJECT;
        put_header(hp, len, 0);
        np = hp + HDR + len;
        put_header(np, 0, hf - need);
        wp = np >= RING ? 0 : np;
        a_cur = hp + HDR;
        a_rem = len;
        nx = wp + (hf - need) + HDR;
        if (nx >= RING) nx = 0;
        for (int i = 0; i < NRD; i++) begin
            p = rpos[i];
            if (all) rpos[i] = nx;
            else if (nx > lastp) begin
                if (p > lastp && p < nx) rpos[i] = nx;
            end else if (p > lastp || p < nx) rpos[i] = nx;
        end
        return ST_OK;
    endfunction

    function automatic answer_t ring_step(cmd_item_t it);
        answer_t a;
        int unsigned pos, guard, lim, l, st, nx;
        bit found;
        a = '0;
        case (it.cmd)
            CMD_CLEAR: ring_clear();
            CMD_ACQUIRE: begin
                a.st = ST_EMPTY;
                a.rid = RID_NONE;
                for (int i = 0; i < NRD; i++)
                    if (!busy_mask[i]) begin
                        busy_mask[i] = 1'b1;
                        rpos[i] = wp;
                        a.st = ST_OK;
                        a.rid = 4'(i);
                        break;
                    end
            end
            CMD_RELEASE: busy_mask[it.rd] = 1'b0;
            CMD_APPEND: a.st = place_record(it.len);
            CMD_APPEND_BYTE: begin
                if (a_rem == 0) a.st = ST_REJECT;
                else begin
                    if (a_cur >= RING) a_cur = 0;
                    mwr(a_cur, it.dat);
                    a_cur++;
                    a_rem--;
                end
            end
            CMD_READ: begin
                r_rem = 0;
                a.st = ST_EMPTY;
                pos = rpos[it.rd];
                guard = 0;
                lim = RING / HDR + 2;
                found = 0;
                if (pos >= RING) pos = 0;
                if (pos != wp) begin
                    found = 1;
                    while (blk_len(pos) == 0) begin
                        if (pos == wp || guard > lim) begin
                            found = 0;
                            break;
                        end
                        pos += blk_free(pos) + HDR;
                        if (pos >= RING) pos = 0;
                        guard++;
                    end
                end
                if (found) begin
                    l = blk_len(pos);
                    st = pos + HDR;
                    nx = st + l + blk_free(pos);
                    if (nx >= RING) nx = 0;
                    rpos[it.rd] = nx;
                    a.rlen = 13'(l);
                    if (l > it.len) a.st = ST_TOO_BIG;
                    else begin
                        a.st = ST_OK;
                        r_cur = st;
                        r_rem = l;
                    end
                end
            end
            CMD_READ_BYTE: begin
                if (r_rem == 0) a.st = ST_EMPTY;
                else begin
                    if (r_cur >= RING) r_cur = 0;
                    a.ob = 8'(mrd(r_cur));
                    r_cur++;
                    r_rem--;
                    a.lst = r_rem == 0;
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    function automatic void push_cmd(int c, int r = 0, int l = 0, int d = 0);
        pending_cmds.push_back('{3'(c), 3'(r), 13'(l), 8'(d)});
    endfunction

    function automatic int pick_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 70) return $urandom_range(0, 40);
        if (k < 90) return $urandom_range(0, 600);
        if (k < 97) return $urandom_range(3000, RING - 2 * HDR);
        return $urandom_range(RING - 2 * HDR + 1, 8191);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start <= 1'b0;
            command <= '0; reader <= '0; length <= '0; data_byte <= '0;
        end else begin
            cycles <= cycles + 1;
            if (cycles % 1000 == 0) quiet_stretch <= ($urandom_range(0, 3) == 0);
            if (!start || !busy) begin
                if (pending_cmds.size() > 0 && (quiet_stretch || $urandom_range(0, 99) >= 12))
                begin
                    cmd_item_t it;
                    it = pending_cmds.pop_front();
                    expected_answers.push_back(ring_step(it));
                    start <= 1'b1;
                    command <= it.cmd; reader <= it.rd; length <= it.len; data_byte <= it.dat;
                end else
                    start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        if (rst_n && done) begin
            if (expected_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
            end else begin
                answer_t e, g;
                e = expected_answers.pop_front();
                g = '{status, reader_id, record_length, out_byte, last};
                if (g !== e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st=%0d rid=%0d len=%0d byte=%0h last=%0d, got st=%0d rid=%0d len=%0d byte=%0h last=%0d",
                                 e.st, e.rid, e.rlen, e.ob, e.lst,
                                 g.st, g.rid, g.rlen, g.ob, g.lst);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("multi_reader_record_ring_tb failed");
            $finish;
        end
    end

    initial begin
        int n, k, l;
        foreach (mem[i]) mem[i] = 0;
        ring_clear();
        rst_n = 1'b0;
        start = 1'b0;
        command = '0; reader = '0; length = '0; data_byte = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes and corner cases
        push_cmd(CMD_APPEND_BYTE, 0, 0, 8'hFF);
        push_cmd(CMD_READ_BYTE);
        push_cmd(CMD_READ, 7, 13'h1FFF);
        push_cmd(CMD_ACQUIRE);
        push_cmd(CMD_ACQUIRE);
        push_cmd(CMD_APPEND, 0, 3);
        push_cmd(CMD_APPEND_BYTE, 0, 0, 8'hFF);
        push_cmd(CMD_APPEND_BYTE, 0, 0, 8'h00);
        push_cmd(CMD_READ, 0, 3);
        push_cmd(CMD_READ_BYTE);
        push_cmd(CMD_APPEND_BYTE, 0, 0, 8'hA5);
        push_cmd(CMD_READ_BYTE);
        push_cmd(CMD_READ_BYTE);
        push_cmd(CMD_READ_BYTE);
        push_cmd(CMD_READ, 1, 0);
        push_cmd(CMD_APPEND, 0, RING - 2 * HDR + 1);
        push_cmd(CMD_APPEND, 0, 13'h1FFF);
        push_cmd(CMD_APPEND, 0, RING - 2 * HDR);
        push_cmd(CMD_APPEND, 0, 0);
        push_cmd(CMD_READ, 2, 13'h1FFF);
        push_cmd(CMD_RELEASE, 0);
        push_cmd(CMD_RELEASE, 7);
        push_cmd(CMD_READ, 1, 0);
        push_cmd(3'd7, 3'd7, 13'h1FFF, 8'hFF);
        push_cmd(CMD_CLEAR);
        for (int i = 0; i < 9; i++) push_cmd(CMD_ACQUIRE);

        // random: mostly well-formed append and read sequences
        n = 0;
        while (n < 1400) begin
            k = $urandom_range(0, 99);
            if (k < 40) begin
                l = pick_len();
                push_cmd(CMD_APPEND, $urandom, l, $urandom);
                n++;
                if (l <= 40)
                    for (int i = 0; i < l + $urandom_range(0, 1); i++) begin
                        push_cmd(CMD_APPEND_BYTE, $urandom, $urandom, $urandom);
                        n++;
                    end
            end else if (k < 75) begin
                push_cmd(CMD_READ, $urandom, $urandom_range(0, 3) == 0 ? $urandom : 13'd64,
                         $urandom);
                n++;
                for (int i = $urandom_range(0, 45); i > 0; i--) begin
                    push_cmd(CMD_READ_BYTE, $urandom, $urandom, $urandom);
                    n++;
                end
            end else if (k < 85) begin
                push_cmd(CMD_ACQUIRE, $urandom, $urandom, $urandom);
                n++;
            end else if (k < 93) begin
                push_cmd(CMD_RELEASE, $urandom, $urandom, $urandom);
                n++;
            end else if (k < 95) begin
                push_cmd(CMD_CLEAR, $urandom, $urandom, $urandom);
                n++;
            end else begin
                push_cmd($urandom_range(0, 7), $urandom, $urandom, $urandom);
                n++;
            end
        end

        wait (pending_cmds.size() == 0 && expected_answers.size() == 0);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_answers.size() == 0)
            $display("multi_reader_record_ring_tb passed");
        else
            $display("multi_reader_record_ring_tb failed");
        $finish;
    end
endmodule

// ----- files.f -----
design/mrrr_pkg.sv
design/mrrr_ram.sv
design/mrrr_ctrl.sv
design/multi_reader_record_ring.sv
verif/multi_reader_record_ring_tb.sv
